@@ design/fpa_pkg.sv @@
// Shared types, codes and helpers for the Q24.8 fixed-point ALU.
// Used by fpa_front, fpa_fifo, fpa_back and fixed_point_alu_q24_8.
package fpa_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_TO_INT   = 4'd14,
    CMD_FROM_INT = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Work left for the back end once the front end has classified a transaction.
  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [DATA_W-1:0]  res;
    logic               cmp;
    status_e            st;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;
    logic               neg;
  } item_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Clamps a 33-bit signed value to the signed 32-bit range.
  function automatic sat_t sat33(input logic [DATA_W:0] v);
    sat_t r;
    r.sat = v[DATA_W] ^ v[DATA_W-1];
    if (r.sat) begin
      r.val = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/fpa_front.sv @@
// Front end: decodes the command, finishes every operation other than multiply
// and divide, and prepares magnitudes and sign for those two. Depends on fpa_pkg.
module fpa_front #(
  parameter int FRACTION_BITS = 8
) (
  input  logic [fpa_pkg::CMD_W-1:0]  command_i,
  input  logic [fpa_pkg::DATA_W-1:0] operand_a_i,
  input  logic [fpa_pkg::DATA_W-1:0] operand_b_i,
  output fpa_pkg::item_t             item_o
);

  localparam int W = fpa_pkg::DATA_W;

  logic signed [W-1:0]               a, b;
  logic [W:0]                        sum, diff, incr, decr;
  logic signed [W+FRACTION_BITS-1:0] scaled;
  logic [FRACTION_BITS:0]            scaled_hi;
  fpa_pkg::sat_t                     sat;
  fpa_pkg::cmd_e                     cmd;

  assign a = operand_a_i;
  assign b = operand_b_i;
  assign cmd = fpa_pkg::cmd_e'(command_i);

  assign sum    = {a[W-1], a} + {b[W-1], b};
  assign diff   = {a[W-1], a} - {b[W-1], b};
  assign incr   = {a[W-1], a} + (W+1)'(1);
  assign decr   = {a[W-1], a} - (W+1)'(1);
  assign scaled = {a, {FRACTION_BITS{1'b0}}};
  assign scaled_hi = scaled[W+FRACTION_BITS-1:W-1];

  always_comb begin
    item_o       = '0;
    item_o.kind  = fpa_pkg::KIND_DONE;
    item_o.st    = fpa_pkg::ST_OK;
    item_o.mag_a = a[W-1] ? W'(-a) : a;
    item_o.mag_b = b[W-1] ? W'(-b) : b;
    item_o.neg   = a[W-1] ^ b[W-1];
    sat          = '0;
    case (cmd)
      fpa_pkg::CMD_ADD:    sat = fpa_pkg::sat33(sum);
      fpa_pkg::CMD_SUB:    sat = fpa_pkg::sat33(diff);
      fpa_pkg::CMD_INC:    sat = fpa_pkg::sat33(incr);
      fpa_pkg::CMD_DEC:    sat = fpa_pkg::sat33(decr);
      fpa_pkg::CMD_MUL:    item_o.kind = fpa_pkg::KIND_MUL;
      fpa_pkg::CMD_DIV:    item_o.kind = fpa_pkg::KIND_DIV;
      fpa_pkg::CMD_GT:     item_o.cmp = a > b;
      fpa_pkg::CMD_LT:     item_o.cmp = a < b;
      fpa_pkg::CMD_GE:     item_o.cmp = a >= b;
      fpa_pkg::CMD_LE:     item_o.cmp = a <= b;
      fpa_pkg::CMD_EQ:     item_o.cmp = a == b;
      fpa_pkg::CMD_NE:     item_o.cmp = a != b;
      fpa_pkg::CMD_MIN:    sat.val = (a < b) ? a : b;
      fpa_pkg::CMD_MAX:    sat.val = (a > b) ? a : b;
      fpa_pkg::CMD_TO_INT: sat.val = W'(a >>> FRACTION_BITS);
      fpa_pkg::CMD_FROM_INT: begin
        // The shifted value fits only when its top bits are all copies of the sign.
        if (scaled_hi != '0 && scaled_hi != '1) begin
          sat.sat = 1'b1;
          sat.val = a[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
          sat.val = scaled[W-1:0];
        end
      end
      default: sat = '0;
    endcase
    item_o.res = sat.val;
    if (sat.sat) begin
      item_o.st = fpa_pkg::ST_SAT;
    end
  end

endmodule

@@ design/fpa_fifo.sv @@
// Two-entry queue between the front and back ends.
// Depends on fpa_pkg for the transaction type.
module fpa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpa_pkg::item_t item_i,
  input  logic           pop_i,
  output fpa_pkg::item_t item_o,
  output logic           nempty_o,
  output logic           full_o
);

  fpa_pkg::item_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q, cnt_d;

  assign item_o   = mem_q[rd_q];
  assign nempty_o = cnt_q != 2'd0;
  assign full_o   = cnt_q == 2'd2;
  assign cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

endmodule

@@ design/fpa_back.sv @@
// Back end: registered multiplier, one-bit-per-stage pipelined divider, then
// rounding, saturation and the output register. Depends on fpa_pkg.
module fpa_back #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fpa_pkg::item_t             item_i,
  input  logic                       nempty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fpa_pkg::DATA_W-1:0] result_value_o,
  output logic                       compare_true_o,
  output logic [1:0]                 status_o
);

  localparam int W  = fpa_pkg::DATA_W;
  localparam int NW = W + FRACTION_BITS + 1;  // width of the doubled dividend
  localparam int PW = 2 * W;

  typedef struct packed {
    fpa_pkg::kind_e kind;
    logic [W-1:0]   res;
    logic           cmp;
    fpa_pkg::status_e st;
    logic           neg;
    logic [PW-1:0]  prod;
    logic [W:0]     den;
    logic [W:0]     rem;
    logic [NW-1:0]  nq;
  } stage_t;

  stage_t         stg_q [NW+1];
  stage_t         stg_d [NW+1];
  logic [NW:0]    vld_q;
  logic           en;
  logic           out_v_q;
  logic [W-1:0]   res_q;
  logic           cmp_q;
  fpa_pkg::status_e st_q;
  logic [W+1:0]   trial [NW];
  logic [PW-1:0]  mag;
  logic [PW-1:0]  rounded;
  logic [W-1:0]   res_d;
  fpa_pkg::status_e st_d;

  assign en    = !(out_v_q && out_stall_i);
  assign pop_o = en && nempty_i;

  always_comb begin
    stg_d[0]      = '0;
    stg_d[0].kind = item_i.kind;
    stg_d[0].res  = item_i.res;
    stg_d[0].cmp  = item_i.cmp;
    stg_d[0].st   = item_i.st;
    stg_d[0].neg  = item_i.neg;
    stg_d[0].prod = PW'(item_i.mag_a) * PW'(item_i.mag_b);
    stg_d[0].den  = {item_i.mag_b, 1'b0};
    stg_d[0].nq   = {item_i.mag_a, {(FRACTION_BITS+1){1'b0}}} + NW'(item_i.mag_b);
    for (int k = 0; k < NW; k++) begin
      stg_d[k+1] = stg_q[k];
      trial[k]   = {stg_q[k].rem, stg_q[k].nq[NW-1]};
      if (trial[k] >= {1'b0, stg_q[k].den}) begin
        stg_d[k+1].rem = (W+1)'(trial[k] - {1'b0, stg_q[k].den});
        stg_d[k+1].nq  = {stg_q[k].nq[NW-2:0], 1'b1};
      end else begin
        stg_d[k+1].rem = trial[k][W:0];
        stg_d[k+1].nq  = {stg_q[k].nq[NW-2:0], 1'b0};
      end
    end
  end

  // Final stage: round product, pick magnitude, apply sign, clamp, flag div by zero.
  always_comb begin
    rounded = stg_q[NW].prod + (PW'(1) << (FRACTION_BITS - 1));
    if (stg_q[NW].kind == fpa_pkg::KIND_MUL) begin
      mag = rounded >> FRACTION_BITS;
    end else begin
      mag = PW'(stg_q[NW].nq);
    end
    res_d = stg_q[NW].res;
    st_d  = stg_q[NW].st;
    if (stg_q[NW].kind != fpa_pkg::KIND_DONE) begin
      st_d = fpa_pkg::ST_OK;
      if (stg_q[NW].kind == fpa_pkg::KIND_DIV && stg_q[NW].den == '0) begin
        st_d  = fpa_pkg::ST_DIV0;
        res_d = '0;
      end else if (stg_q[NW].neg) begin
        if (mag > (PW'(1) << (W - 1))) begin
          st_d  = fpa_pkg::ST_SAT;
          res_d = {1'b1, {(W-1){1'b0}}};
        end else begin
          res_d = W'(-mag);
        end
      end else if (mag > PW'({1'b0, {(W-1){1'b1}}})) begin
        st_d  = fpa_pkg::ST_SAT;
        res_d = {1'b0, {(W-1){1'b1}}};
      end else begin
        res_d = mag[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= NW; k++) begin
        stg_q[k] <= stg_d[k];
      end
      res_q <= res_d;
      cmp_q <= stg_q[NW].cmp;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[NW-1:0], nempty_i};
      out_v_q <= vld_q[NW];
    end
  end

  assign out_valid_o    = out_v_q;
  assign result_value_o = res_q;
  assign compare_true_o = cmp_q;
  assign status_o       = st_q;

endmodule

@@ design/fixed_point_alu_q24_8.sv @@
// Top level of the Q24.8 fixed-point ALU.
// Instantiates fpa_front, fpa_fifo and fpa_back; depends on fpa_pkg.
//
// The ALU takes one transaction per cycle: a 4-bit command and two signed
// raw fixed-point operands with FRACTION_BITS fractional bits, and returns
// exactly one result per transaction in the order taken. It handles add,
// subtract, multiply, divide, six comparisons, min, max, increment,
// decrement and conversions to and from integer. Multiply and divide are
// exact and round halves away from zero; results beyond the signed 32-bit
// range clamp and report saturation, and divide by zero returns 0 with an
// error status. The front end finishes the simple commands in its decode
// logic and writes every transaction into a two-entry queue. The back end
// runs all transactions through the same pipeline so order is kept: a
// registered 32x32 multiplier and a restoring divider that retires one
// quotient bit per stage over FRACTION_BITS + 33 stages, followed by a
// rounding and clamping stage that loads the output register. While the
// output is not stalled, throughput is one transaction per cycle. A stall
// on the output freezes the back end while the queue keeps taking input
// until it is full.
module fixed_point_alu_q24_8 #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [3:0]                 command_i,
  input  logic signed [31:0]         operand_a_i,
  input  logic signed [31:0]         operand_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         result_value_o,
  output logic                       compare_true_o,
  output logic [1:0]                 status_o
);

  fpa_pkg::item_t front_item, head_item;
  logic           push, pop, nempty, full;

  // A transaction is taken whenever the queue has room.
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  fpa_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .command_i  (command_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .item_o     (front_item)
  );

  fpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .nempty_o(nempty),
    .full_o  (full)
  );

  fpa_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (head_item),
    .nempty_i      (nempty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .compare_true_o(compare_true_o),
    .status_o      (status_o)
  );

endmodule
